// File: design/scl_pkg.sv
// Shared types and constants of the serial command line decoder.
// Used by the top level, the command decoder and the checker; no dependencies.
package scl_pkg;

   localparam int LINE_LENGTH = 8;
   localparam int POS_W = $clog2(LINE_LENGTH + 1);
   localparam int ACC_W = 20;

   localparam logic [2:0] ACTION_NONE  = 3'd0;
   localparam logic [2:0] ACTION_WRITE = 3'd1;
   localparam logic [2:0] ACTION_START = 3'd2;
   localparam logic [2:0] ACTION_STOP  = 3'd3;
   localparam logic [2:0] ACTION_INFO  = 3'd4;
   localparam logic [2:0] ACTION_RESET = 3'd5;
   localparam logic [2:0] ACTION_ERROR = 3'd6;
   localparam logic [2:0] ACTION_FLAG  = 3'd7;

   localparam logic [1:0] PHASE_SKIP   = 2'd0;
   localparam logic [1:0] PHASE_DIGITS = 2'd1;
   localparam logic [1:0] PHASE_DONE   = 2'd2;

   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_PLUS  = 8'd43;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_EQUAL = 8'd61;
   localparam logic [7:0] CHAR_UP_A  = 8'd65;
   localparam logic [7:0] CHAR_UP_Z  = 8'd90;
   localparam logic [7:0] CASE_SHIFT = 8'd32;

   localparam logic [7:0] CMD_A = 8'h61;
   localparam logic [7:0] CMD_B = 8'h62;
   localparam logic [7:0] CMD_C = 8'h63;
   localparam logic [7:0] CMD_D = 8'h64;
   localparam logic [7:0] CMD_F = 8'h66;
   localparam logic [7:0] CMD_I = 8'h69;
   localparam logic [7:0] CMD_M = 8'h6D;
   localparam logic [7:0] CMD_R = 8'h72;
   localparam logic [7:0] CMD_S = 8'h73;
   localparam logic [7:0] CMD_T = 8'h74;
   localparam logic [7:0] CMD_V = 8'h76;
   localparam logic [7:0] CMD_X = 8'h78;

   localparam logic [3:0] REG_RES  = 4'd1;
   localparam logic [3:0] REG_GAIN = 4'd3;
   localparam logic [3:0] REG_CH1  = 4'd4;
   localparam logic [3:0] REG_CH2  = 4'd5;
   localparam logic [3:0] REG_RLD  = 4'd7;

   localparam logic [7:0] MASK_CH   = 8'b01110111;
   localparam logic [7:0] MASK_RLD  = 8'b00111111;
   localparam logic [7:0] MASK_GAIN = 8'b00001100;
   localparam logic [7:0] MASK_RES  = 8'b00000011;

   localparam int FLAG_STREAM  = 0;
   localparam int FLAG_BINARY  = 1;
   localparam int FLAG_FULL    = 2;
   localparam int FLAG_VERBOSE = 3;
   localparam logic [3:0] FLAGS_RESET = 4'b1101;

   typedef struct packed {
      logic [2:0] action;
      logic [3:0] reg_index;
      logic [7:0] reg_value;
      logic       ok_ack;
      logic [3:0] flags;
   } cmd_result_type;

endpackage

// File: design/scl_cmd_decode.sv
// Decodes a finished command line (letter and signed number) into an action.
// Depends on scl_pkg.
module scl_cmd_decode (
   input  logic [7:0]              letter,
   input  logic [scl_pkg::ACC_W-1:0] number,
   input  logic [3:0]              flags,
   output scl_pkg::cmd_result_type result
);
   import scl_pkg::*;

   logic [7:0] lower;
   logic [7:0] low;
   logic       nz;

   always_comb begin
      lower = letter;
      if (letter >= CHAR_UP_A && letter <= CHAR_UP_Z) begin
         lower = letter + CASE_SHIFT;
      end
      low = number[7:0];
      nz = (number != '0);

      result.action = ACTION_NONE;
      result.reg_index = '0;
      result.reg_value = '0;
      result.ok_ack = 1'b0;
      result.flags = flags;

      unique case (lower)
         CMD_A: begin
            result.action = ACTION_WRITE;
            result.reg_index = REG_CH1;
            result.reg_value = low & MASK_CH;
            result.ok_ack = 1'b1;
         end
         CMD_B: begin
            result.action = ACTION_WRITE;
            result.reg_index = REG_CH2;
            result.reg_value = low & MASK_CH;
            result.ok_ack = 1'b1;
         end
         CMD_C: begin
            result.action = ACTION_WRITE;
            result.reg_index = REG_RLD;
            result.reg_value = low & MASK_RLD;
            result.ok_ack = 1'b1;
         end
         CMD_I: begin
            result.action = ACTION_WRITE;
            result.reg_index = REG_GAIN;
            result.reg_value = {low[5:0], 2'b00} & MASK_GAIN;
            result.ok_ack = 1'b1;
         end
         CMD_R: begin
            result.action = ACTION_WRITE;
            result.reg_index = REG_RES;
            result.reg_value = low & MASK_RES;
            result.ok_ack = 1'b1;
         end
         CMD_X: begin
            if (low != '0) begin
               result.flags[FLAG_STREAM] = 1'b1;
               result.action = ACTION_START;
            end else begin
               result.flags[FLAG_STREAM] = 1'b0;
               result.action = ACTION_STOP;
               result.ok_ack = 1'b1;
            end
         end
         CMD_D: begin
            result.flags[FLAG_BINARY] = nz;
            result.action = ACTION_FLAG;
            result.ok_ack = 1'b1;
         end
         CMD_F: begin
            result.flags[FLAG_FULL] = nz;
            result.action = ACTION_FLAG;
            result.ok_ack = 1'b1;
         end
         CMD_V: begin
            result.flags[FLAG_VERBOSE] = nz;
            result.action = ACTION_FLAG;
            result.ok_ack = 1'b1;
         end
         CMD_T: begin
            result.ok_ack = 1'b1;
         end
         CMD_S: begin
            if (!flags[FLAG_STREAM]) begin
               result.action = ACTION_INFO;
            end
         end
         CMD_M: begin
            result.flags[FLAG_STREAM] = 1'b0;
            result.action = ACTION_RESET;
         end
         default: begin
            result.action = ACTION_ERROR;
         end
      endcase
   end

endmodule

// File: design/serial_command_line_decoder.sv
// Top level of the serial command line decoder: line buffer, number parser,
// mode flags and the result register. Depends on scl_pkg and scl_cmd_decode.
//
//   port group   direction   carries
//   req_*        in          one received byte per beat
//   rsp_*        out         one decoded result per received byte
//   csr_*        in          the ignore-input control bit
//
// Each byte is parsed and decoded in the cycle it is accepted; its result
// appears on the rsp port on the next cycle, one beat per cycle while rsp_stall is low.
// The result is held in a single result register.
// A stalled result holds the request side only while that register is full.
// Reset clears the line, the number parser and sets the mode flags to their defaults.
module serial_command_line_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_action,
   output logic [3:0] rsp_reg_index,
   output logic [7:0] rsp_reg_value,
   output logic       rsp_ok_ack,
   output logic       rsp_streaming,
   output logic       rsp_binary_format,
   output logic       rsp_full_frame,
   output logic       rsp_verbose_on,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);
   import scl_pkg::*;

   logic             ignore_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       letter_ff, letter_in;
   logic [7:0]       second_ff, second_in;
   logic [ACC_W-1:0] accum_ff, accum_in;
   logic             neg_ff, neg_in;
   logic [1:0]       phase_ff, phase_in;
   logic [3:0]       flags_ff, flags_in;

   logic             rsp_valid_ff;
   logic [2:0]       action_ff, action_in;
   logic [3:0]       index_ff, index_in;
   logic [7:0]       value_ff, value_in;
   logic             ack_ff, ack_in;
   logic [3:0]       out_flags_ff;

   logic             accept;
   logic             active;
   logic             line_end;
   logic             in_window;
   logic             is_digit;
   logic             is_blank;
   logic             do_decode;
   logic [ACC_W-1:0] number;
   logic [ACC_W-1:0] accum_x10;
   cmd_result_type   dec;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;
   assign active = accept && !ignore_ff;

   assign line_end = (req_rx_byte == CHAR_CR) || (req_rx_byte == CHAR_LF);
   assign in_window = (pos_ff < POS_W'(LINE_LENGTH));
   assign is_digit = (req_rx_byte >= CHAR_ZERO) && (req_rx_byte <= CHAR_NINE);
   assign is_blank = (req_rx_byte == CHAR_SPACE) ||
                     ((req_rx_byte >= CHAR_TAB) && (req_rx_byte <= CHAR_CR));
   assign do_decode = line_end && (second_ff == CHAR_EQUAL) && (pos_ff >= POS_W'(2));
   assign number = neg_ff ? (ACC_W'(0) - accum_ff) : accum_ff;
   assign accum_x10 = (accum_ff << 3) + (accum_ff << 1);

   scl_cmd_decode u_decode (
      .letter (letter_ff),
      .number (number),
      .flags  (flags_ff),
      .result (dec)
   );

   always_comb begin
      pos_in = pos_ff;
      letter_in = letter_ff;
      second_in = second_ff;
      accum_in = accum_ff;
      neg_in = neg_ff;
      phase_in = phase_ff;
      flags_in = flags_ff;
      action_in = ACTION_NONE;
      index_in = '0;
      value_in = '0;
      ack_in = 1'b0;

      if (active) begin
         if (in_window) begin
            pos_in = pos_ff + POS_W'(1);
            if (pos_ff == POS_W'(0)) begin
               letter_in = req_rx_byte;
            end else if (pos_ff == POS_W'(1)) begin
               second_in = req_rx_byte;
            end else if (phase_ff == PHASE_SKIP && is_blank) begin
               phase_in = PHASE_SKIP;
            end else if (phase_ff == PHASE_SKIP &&
                         (req_rx_byte == CHAR_PLUS || req_rx_byte == CHAR_MINUS)) begin
               neg_in = (req_rx_byte == CHAR_MINUS);
               phase_in = PHASE_DIGITS;
            end else if ((phase_ff == PHASE_SKIP || phase_ff == PHASE_DIGITS) && is_digit) begin
               accum_in = accum_x10 + ACC_W'(req_rx_byte[3:0]);
               phase_in = PHASE_DIGITS;
            end else begin
               phase_in = PHASE_DONE;
            end
         end
         if (line_end) begin
            if (do_decode) begin
               action_in = dec.action;
               index_in = dec.reg_index;
               value_in = dec.reg_value;
               ack_in = dec.ok_ack;
               flags_in = dec.flags;
            end
            pos_in = '0;
            letter_in = '0;
            second_in = '0;
            accum_in = '0;
            neg_in = 1'b0;
            phase_in = PHASE_SKIP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_ff <= 1'b0;
         pos_ff <= '0;
         letter_ff <= '0;
         second_ff <= '0;
         accum_ff <= '0;
         neg_ff <= 1'b0;
         phase_ff <= PHASE_SKIP;
         flags_ff <= FLAGS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            ignore_ff <= csr_write_data;
         end
         pos_ff <= pos_in;
         letter_ff <= letter_in;
         second_ff <= second_in;
         accum_ff <= accum_in;
         neg_ff <= neg_in;
         phase_ff <= phase_in;
         flags_ff <= flags_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= action_in;
         index_ff <= index_in;
         value_ff <= value_in;
         ack_ff <= ack_in;
         out_flags_ff <= flags_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_action = action_ff;
   assign rsp_reg_index = index_ff;
   assign rsp_reg_value = value_ff;
   assign rsp_ok_ack = ack_ff;
   assign rsp_streaming = out_flags_ff[FLAG_STREAM];
   assign rsp_binary_format = out_flags_ff[FLAG_BINARY];
   assign rsp_full_frame = out_flags_ff[FLAG_FULL];
   assign rsp_verbose_on = out_flags_ff[FLAG_VERBOSE];

endmodule

// File: design/scl_checker.sv
// Port-level checker for the serial command line decoder, bound to the top level.
// Depends on scl_pkg.
module scl_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_action,
   input logic [3:0] rsp_reg_index,
   input logic [7:0] rsp_reg_value,
   input logic       rsp_streaming
);
   import scl_pkg::*;

   // A stalled result beat must hold.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_action))
      else $error("stalled result beat changed");

   // Every accepted byte produces a result beat on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted byte gave no result beat");

   // Register index and value are zero unless a register write is reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != ACTION_WRITE |-> rsp_reg_index == '0 && rsp_reg_value == '0)
      else $error("register fields set without a register write");

   // Start streaming leaves the flag set; stop and reset leave it clear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACTION_START |-> rsp_streaming)
      else $error("streaming flag clear after start");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == ACTION_STOP || rsp_action == ACTION_RESET) |-> !rsp_streaming)
      else $error("streaming flag set after stop or reset");

endmodule

bind serial_command_line_decoder scl_checker u_scl_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_action    (rsp_action),
   .rsp_reg_index (rsp_reg_index),
   .rsp_reg_value (rsp_reg_value),
   .rsp_streaming (rsp_streaming)
);

// File: dv/tb.sv
// Self-checking testbench for the serial command line decoder: drives directed and
// random command lines with random idling on both channels and checks every result beat.
// Depends on scl_pkg and the design sources of serial_command_line_decoder.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import scl_pkg::*;

   class line_decoder_model;
      bit             ignore_input;
      int             line_pos;
      logic [7:0]     letter_q;
      logic [7:0]     second_q;
      logic [19:0]    accum;
      bit             negative;
      logic [1:0]     phase;
      logic [3:0]     flags;
      int             mismatches;
      cmd_result_type expected_results[$];

      function new();
         ignore_input = 1'b0;
         flags = FLAGS_RESET;
         mismatches = 0;
         clear_line();
      endfunction

      function void clear_line();
         line_pos = 0;
         letter_q = '0;
         second_q = '0;
         accum = '0;
         negative = 1'b0;
         phase = PHASE_SKIP;
      endfunction

      function void set_ignore(bit on);
         ignore_input = on;
      endfunction

      function void parse_number(logic [7:0] c);
         bit digit;
         digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
         if (phase == PHASE_SKIP) begin
            if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) return;
            if (c == CHAR_PLUS || c == CHAR_MINUS) begin
               negative = (c == CHAR_MINUS);
               phase = PHASE_DIGITS;
               return;
            end
         end
         if (phase <= PHASE_DIGITS && digit) begin
            accum = 20'(accum * 10 + 20'(c - CHAR_ZERO));
            phase = PHASE_DIGITS;
         end else begin
            phase = PHASE_DONE;
         end
      endfunction

      function void predict_result(logic [7:0] c);
         cmd_result_type r;
         logic [19:0]    num;
         logic [7:0]     low;
         logic [7:0]     letter;
         r = '0;
         if (!ignore_input) begin
            if (line_pos < LINE_LENGTH) begin
               if (line_pos == 0) letter_q = c;
               else if (line_pos == 1) second_q = c;
               else parse_number(c);
               line_pos++;
            end
            if (c == CHAR_CR || c == CHAR_LF) begin
               if (second_q == CHAR_EQUAL && line_pos > 1) begin
                  num = negative ? (20'd0 - accum) : accum;
                  low = num[7:0];
                  letter = letter_q;
                  if (letter >= CHAR_UP_A && letter <= CHAR_UP_Z) letter = letter + CASE_SHIFT;
                  case (letter)
                     CMD_A: begin
                        r.action = ACTION_WRITE; r.reg_index = REG_CH1;
                        r.reg_value = low & MASK_CH; r.ok_ack = 1'b1;
                     end
                     CMD_B: begin
                        r.action = ACTION_WRITE; r.reg_index = REG_CH2;
                        r.reg_value = low & MASK_CH; r.ok_ack = 1'b1;
                     end
                     CMD_C: begin
                        r.action = ACTION_WRITE; r.reg_index = REG_RLD;
                        r.reg_value = low & MASK_RLD; r.ok_ack = 1'b1;
                     end
                     CMD_I: begin
                        r.action = ACTION_WRITE; r.reg_index = REG_GAIN;
                        r.reg_value = (low << 2) & MASK_GAIN; r.ok_ack = 1'b1;
                     end
                     CMD_R: begin
                        r.action = ACTION_WRITE; r.reg_index = REG_RES;
                        r.reg_value = low & MASK_RES; r.ok_ack = 1'b1;
                     end
                     CMD_X: begin
                        if (low != 0) begin
                           flags[FLAG_STREAM] = 1'b1;
                           r.action = ACTION_START;
                        end else begin
                           flags[FLAG_STREAM] = 1'b0;
                           r.action = ACTION_STOP;
                           r.ok_ack = 1'b1;
                        end
                     end
                     CMD_D: begin
                        flags[FLAG_BINARY] = (num != 0); r.action = ACTION_FLAG; r.ok_ack = 1'b1;
                     end
                     CMD_F: begin
                        flags[FLAG_FULL] = (num != 0); r.action = ACTION_FLAG; r.ok_ack = 1'b1;
                     end
                     CMD_V: begin
                        flags[FLAG_VERBOSE] = (num != 0); r.action = ACTION_FLAG; r.ok_ack = 1'b1;
                     end
                     CMD_T: begin
                        r.ok_ack = 1'b1;
                     end
                     CMD_S: begin
                        if (!flags[FLAG_STREAM]) r.action = ACTION_INFO;
                     end
                     CMD_M: begin
                        flags[FLAG_STREAM] = 1'b0; r.action = ACTION_RESET;
                     end
                     default: begin
                        r.action = ACTION_ERROR;
                     end
                  endcase
               end
               clear_line();
            end
         end
         r.flags = flags;
         expected_results.push_back(r);
      endfunction

      function void check_result(cmd_result_type got);
         cmd_result_type exp;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result beat with nothing expected: action %0d idx %0d val %02h",
                        $realtime, got.action, got.reg_index, got.reg_value);
            return;
         end
         exp = expected_results.pop_front();
         if (got.action != exp.action || got.reg_index != exp.reg_index ||
             got.reg_value != exp.reg_value || got.ok_ack != exp.ok_ack ||
             got.flags != exp.flags) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: mismatch: expected action %0d idx %0d val %02h ack %b flags %b,",
                         " got action %0d idx %0d val %02h ack %b flags %b"}, $realtime,
                        exp.action, exp.reg_index, exp.reg_value, exp.ok_ack, exp.flags,
                        got.action, got.reg_index, got.reg_value, got.ok_ack, got.flags);
         end
      endfunction

      function int pending_count();
         return expected_results.size();
      endfunction

      function int mismatch_count();
         return mismatches;
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [2:0] rsp_action;
   logic [3:0] rsp_reg_index;
   logic [7:0] rsp_reg_value;
   logic       rsp_ok_ack;
   logic       rsp_streaming;
   logic       rsp_binary_format;
   logic       rsp_full_frame;
   logic       rsp_verbose_on;
   logic       csr_write_enable;
   logic       csr_write_data;

   cmd_result_type    observed;
   line_decoder_model model;
   bit                calm;
   bit                ignoring;
   int                counted_bytes;
   logic [7:0]        burst[$];
   logic [7:0]        command_letters [12] = '{CMD_A, CMD_B, CMD_C, CMD_D, CMD_F, CMD_I,
                                                CMD_M, CMD_R, CMD_S, CMD_T, CMD_V, CMD_X};

   serial_command_line_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_action        (rsp_action),
      .rsp_reg_index     (rsp_reg_index),
      .rsp_reg_value     (rsp_reg_value),
      .rsp_ok_ack        (rsp_ok_ack),
      .rsp_streaming     (rsp_streaming),
      .rsp_binary_format (rsp_binary_format),
      .rsp_full_frame    (rsp_full_frame),
      .rsp_verbose_on    (rsp_verbose_on),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   assign observed = {rsp_action, rsp_reg_index, rsp_reg_value, rsp_ok_ack,
                      rsp_verbose_on, rsp_full_frame, rsp_binary_format, rsp_streaming};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int gap_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) model.check_result(observed);
         if (req_valid && !req_stall) model.predict_result(req_rx_byte);
      end
   end

   initial begin
      int n;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         n = gap_len();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         repeat ($urandom_range(0, 5)) @(posedge clock);
      end
   end

   task automatic send_byte(logic [7:0] b);
      int n;
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      if (!ignoring) counted_bytes++;
      n = gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_burst();
      foreach (burst[i]) send_byte(burst[i]);
      burst.delete();
   endtask

   task automatic send_line(string s, bit use_lf);
      for (int i = 0; i < s.len(); i++) burst.push_back(s[i]);
      burst.push_back(use_lf ? CHAR_LF : CHAR_CR);
      send_burst();
   endtask

   task automatic set_ignore_input(bit on);
      req_valid <= 1'b0;
      do @(posedge clock); while (model.pending_count() != 0);
      csr_write_enable <= 1'b1;
      csr_write_data <= on;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model.set_ignore(on);
      ignoring = on;
   endtask

   task automatic build_random_line();
      logic [7:0] letter;
      int         n;
      bit         binary_digits;
      if ($urandom_range(0, 99) < 80) begin
         if ($urandom_range(0, 9) == 0) letter = 8'(CMD_A + $urandom_range(0, 25));
         else letter = command_letters[$urandom_range(0, 11)];
         if ($urandom_range(0, 1)) letter = letter - CASE_SHIFT;
         burst.push_back(letter);
         burst.push_back(CHAR_EQUAL);
         repeat ($urandom_range(0, 2))
            burst.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
         n = $urandom_range(0, 3);
         if (n == 1) burst.push_back(CHAR_PLUS);
         else if (n == 2) burst.push_back(CHAR_MINUS);
         binary_digits = 1'($urandom_range(0, 1));
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 5);
         repeat (n) burst.push_back(8'(CHAR_ZERO + (binary_digits ? $urandom_range(0, 1)
                                                                  : $urandom_range(0, 9))));
         if ($urandom_range(0, 9) == 0) burst.push_back(8'($urandom_range(0, 255)));
         burst.push_back($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
      end else begin
         repeat ($urandom_range(1, 12)) burst.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1)) burst.push_back($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
      end
      send_burst();
   endtask

   initial begin
      model = new();
      calm = 1'b0;
      ignoring = 1'b0;
      counted_bytes = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      set_ignore_input(1'b0);
      send_line("a=-1", 0);
      send_line("B=119", 1);
      send_line("c=\t +63", 0);
      send_line("i=3", 1);
      send_line("R=2", 0);
      send_line("x=0", 0);
      send_line("S=", 1);
      send_line("x=256", 0);
      send_line("X=+7", 1);
      send_line("s=", 0);
      send_line("d=1", 0);
      send_line("f=0", 1);
      send_line("V=-0", 0);
      send_line("t=", 0);
      send_line("m=", 1);
      send_line("q=5", 0);
      send_line("a5", 0);
      send_line("b=123456789", 0);
      send_line("", 1);
      burst.push_back(8'hFF);
      send_line("=9x", 0);
      burst.push_back(8'h00);
      send_line("=", 1);
      send_line("v=1", 0);
      send_line("f=1", 1);

      set_ignore_input(1'b1);
      send_line("x=0", 0);
      set_ignore_input(1'b1);
      repeat (3) build_random_line();
      set_ignore_input(1'b0);

      while (counted_bytes < 850) begin
         if ($urandom_range(0, 39) == 0) begin
            set_ignore_input(1'b1);
            repeat ($urandom_range(1, 4)) build_random_line();
            set_ignore_input(1'b0);
         end
         calm = ($urandom_range(0, 7) == 0);
         build_random_line();
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (model.pending_count() != 0);
      repeat (5) @(posedge clock);
      if (model.mismatch_count() == 0 && model.pending_count() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
